// File: rtl/core/tbik_pkg.sv
package tbik_pkg;

  // Fixed-point formats
  localparam int POS_FRAC_BITS   = 16;
  localparam int ANGLE_FRAC_BITS = 13;

  // Reach margin: round(0.01 * 2^POS_FRAC_BITS)
  localparam int EPS_INT = ((1 << POS_FRAC_BITS) + 50) / 100;
  localparam logic signed [33:0] EPS = 34'(EPS_INT);

  // Cosine unity in Q16, rotation unity in Q28
  localparam logic [16:0]        COS_ONE  = 17'd65536;
  localparam logic signed [35:0] QUAT_ONE = 36'sd268435456;

  // Pi and the arccosine polynomial, all Q30
  localparam logic signed [37:0] PI_Q30 = 38'sd3373259426;
  localparam logic signed [35:0] AC0 = 36'sd1686557207;
  localparam logic signed [35:0] AC1 = -36'sd227756103;
  localparam logic signed [35:0] AC2 = 36'sd79737142;
  localparam logic signed [35:0] AC3 = -36'sd20110433;

  // Register indexes
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_SEG_COUNT = 3'd1;
  localparam logic [2:0] REG_UPPER_LEN = 3'd2;
  localparam logic [2:0] REG_LOWER_LEN = 3'd3;
  localparam logic [2:0] REG_ATTACH_X  = 3'd4;
  localparam logic [2:0] REG_ATTACH_Y  = 3'd5;
  localparam logic [2:0] REG_ATTACH_Z  = 3'd6;

  localparam logic [3:0] SEG_COUNT_TWO = 4'd2;

  typedef struct packed {
    logic signed [31:0] body_origin_x;
    logic signed [31:0] body_origin_y;
    logic signed [31:0] body_origin_z;
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [15:0] knee_angle_now;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] motor_velocity;
    logic               command_valid;
    logic               reach_clamped;
  } out_beat_t;

  // Per-item status that rides along the pipe
  typedef struct packed {
    logic               clamped;
    logic               kill;
    logic signed [15:0] knee;
  } item_tag_t;

endpackage

// File: rtl/core/two_bone_ik_knee_drive.sv
// Two-bone knee drive: hip placement, reach clamp, law of cosines, knee velocity.
// Throughput: one beat per cycle; the whole pipe holds while a result is stalled.
// Depth is set by the 32-stage distance square root, the 16-stage cosine divider
// and the 17-stage square root of the arccosine.
// Reset: synchronous, active low; clears valid bits and loads register defaults.
module two_bone_ik_knee_drive (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tbik_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tbik_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [31:0]          cfg_wdata
);
  import tbik_pkg::*;

  logic               enable_r;
  logic [3:0]         seg_count_r;
  logic [30:0]        upper_len_r, lower_len_r;
  logic signed [31:0] attach_x_r, attach_y_r, attach_z_r;

  logic               adv;
  logic               hip_vld, rch_vld, cos_vld, acos_vld;
  logic [2:0][31:0]   hip_dist;
  logic               hip_sat;
  item_tag_t          hip_tag, rch_tag, cos_tag, acos_tag;
  logic signed [33:0] rch_d;
  logic [16:0]        cos_cmag;
  logic               cos_neg;
  logic signed [31:0] acos_vel;
  logic               cmd_ok;

  logic      out_valid_r;
  out_beat_t out_data_r, out_data_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      seg_count_r <= SEG_COUNT_TWO;
      upper_len_r <= 31'd65536;
      lower_len_r <= 31'd65536;
      attach_x_r  <= '0;
      attach_y_r  <= '0;
      attach_z_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ENABLE:    enable_r    <= cfg_wdata[0];
        REG_SEG_COUNT: seg_count_r <= cfg_wdata[3:0];
        REG_UPPER_LEN: upper_len_r <= cfg_wdata[30:0];
        REG_LOWER_LEN: lower_len_r <= cfg_wdata[30:0];
        REG_ATTACH_X:  attach_x_r  <= cfg_wdata;
        REG_ATTACH_Y:  attach_y_r  <= cfg_wdata;
        REG_ATTACH_Z:  attach_z_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless a result beat is held
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  tbik_hip u_hip (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (in_valid),
    .in_beat  (in_data),
    .attach_x (attach_x_r),
    .attach_y (attach_y_r),
    .attach_z (attach_z_r),
    .out_vld  (hip_vld),
    .out_dist (hip_dist),
    .out_sat  (hip_sat),
    .out_tag  (hip_tag)
  );

  tbik_reach u_reach (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .in_vld       (hip_vld),
    .in_dist      (hip_dist),
    .in_sat       (hip_sat),
    .in_tag       (hip_tag),
    .upper_length (upper_len_r),
    .lower_length (lower_len_r),
    .out_vld      (rch_vld),
    .out_d        (rch_d),
    .out_tag      (rch_tag)
  );

  tbik_cos u_cos (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .in_vld       (rch_vld),
    .in_d         (rch_d),
    .in_tag       (rch_tag),
    .upper_length (upper_len_r),
    .lower_length (lower_len_r),
    .out_vld      (cos_vld),
    .out_cmag     (cos_cmag),
    .out_neg      (cos_neg),
    .out_tag      (cos_tag)
  );

  tbik_acos u_acos (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (cos_vld),
    .in_cmag  (cos_cmag),
    .in_neg   (cos_neg),
    .in_tag   (cos_tag),
    .out_vld  (acos_vld),
    .out_vel  (acos_vel),
    .out_tag  (acos_tag)
  );

  // Drop the command when disabled, wrong limb or target too close
  always_comb begin
    cmd_ok = enable_r && (seg_count_r == SEG_COUNT_TWO) && !acos_tag.kill;
    out_data_nxt.command_valid  = cmd_ok;
    out_data_nxt.motor_velocity = cmd_ok ? acos_vel : 32'sd0;
    out_data_nxt.reach_clamped  = cmd_ok && acos_tag.clamped;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= acos_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/tbik_isqrt.sv
module tbik_isqrt #(
  parameter int W  = 64,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [W-1:0]     in_val,
  input  logic [SW-1:0]    in_side,
  output logic             out_vld,
  output logic [W/2-1:0]   out_root,
  output logic [SW-1:0]    out_side
);

  localparam int N = W / 2;

  logic [W-1:0]  rem_r  [N];
  logic [W-1:0]  root_r [N];
  logic [SW-1:0] side_r [N];
  logic [N-1:0]  vld_r;

  // One result bit per stage, most significant first
  for (genvar j = 0; j < N; j++) begin : g_step
    logic [W-1:0]  rem_i, root_i, bit_v, rem_nxt, root_nxt;
    logic [SW-1:0] side_i;
    logic          vld_i;
    logic [W:0]    trial;

    if (j == 0) begin : g_first
      assign rem_i  = in_val;
      assign root_i = '0;
      assign side_i = in_side;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign side_i = side_r[j-1];
      assign vld_i  = vld_r[j-1];
    end

    assign bit_v = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * j);
    assign trial = {1'b0, root_i} + {1'b0, bit_v};

    always_comb begin
      if ({1'b0, rem_i} >= trial) begin
        rem_nxt  = rem_i - trial[W-1:0];
        root_nxt = (root_i >> 1) + bit_v;
      end else begin
        rem_nxt  = rem_i;
        root_nxt = root_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        side_r[j] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1][W/2-1:0];
  assign out_side = side_r[N-1];

endmodule

// File: rtl/core/tbik_hip.sv
module tbik_hip (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  tbik_pkg::in_beat_t  in_beat,
  input  logic signed [31:0]  attach_x,
  input  logic signed [31:0]  attach_y,
  input  logic signed [31:0]  attach_z,
  output logic                out_vld,
  output logic [2:0][31:0]    out_dist,
  output logic                out_sat,
  output tbik_pkg::item_tag_t out_tag
);
  import tbik_pkg::*;

  logic [5:0] vld_r;
  in_beat_t   beat_r [5];

  logic signed [31:0] prd_r [9];
  logic signed [31:0] prd_nxt [9];
  logic signed [35:0] m [9];
  logic signed [21:0] rot_r [9];
  logic signed [21:0] rot_nxt [9];
  logic signed [53:0] term_r [9];
  logic signed [53:0] term_nxt [9];
  logic signed [31:0] att [3];
  logic signed [55:0] acc [3];
  logic signed [41:0] off_r [3];
  logic signed [41:0] off_nxt [3];
  logic signed [31:0] org [3];
  logic signed [31:0] tgt [3];
  logic signed [43:0] hip [3];
  logic signed [44:0] dl [3];
  logic [44:0]        ad [3];
  logic [2:0][31:0]   dist_r, dist_nxt;
  logic               sat_r, sat_nxt;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  // Quaternion pair products
  always_comb begin
    prd_nxt[0] = 32'(beat_r[0].rot_x) * 32'(beat_r[0].rot_x);
    prd_nxt[1] = 32'(beat_r[0].rot_y) * 32'(beat_r[0].rot_y);
    prd_nxt[2] = 32'(beat_r[0].rot_z) * 32'(beat_r[0].rot_z);
    prd_nxt[3] = 32'(beat_r[0].rot_x) * 32'(beat_r[0].rot_y);
    prd_nxt[4] = 32'(beat_r[0].rot_x) * 32'(beat_r[0].rot_z);
    prd_nxt[5] = 32'(beat_r[0].rot_y) * 32'(beat_r[0].rot_z);
    prd_nxt[6] = 32'(beat_r[0].rot_w) * 32'(beat_r[0].rot_x);
    prd_nxt[7] = 32'(beat_r[0].rot_w) * 32'(beat_r[0].rot_y);
    prd_nxt[8] = 32'(beat_r[0].rot_w) * 32'(beat_r[0].rot_z);
  end

  // Rotation matrix in Q28, rounded to Q14
  always_comb begin
    m[0] = QUAT_ONE - 36'sd2 * (36'(prd_r[1]) + 36'(prd_r[2]));
    m[1] = 36'sd2 * (36'(prd_r[3]) - 36'(prd_r[8]));
    m[2] = 36'sd2 * (36'(prd_r[4]) + 36'(prd_r[7]));
    m[3] = 36'sd2 * (36'(prd_r[3]) + 36'(prd_r[8]));
    m[4] = QUAT_ONE - 36'sd2 * (36'(prd_r[0]) + 36'(prd_r[2]));
    m[5] = 36'sd2 * (36'(prd_r[5]) - 36'(prd_r[6]));
    m[6] = 36'sd2 * (36'(prd_r[4]) - 36'(prd_r[7]));
    m[7] = 36'sd2 * (36'(prd_r[5]) + 36'(prd_r[6]));
    m[8] = QUAT_ONE - 36'sd2 * (36'(prd_r[0]) + 36'(prd_r[1]));
    for (int i = 0; i < 9; i++) begin
      rot_nxt[i] = 22'((m[i] + 36'sd8192) >>> 14);
    end
  end

  // Matrix times attachment offset
  always_comb begin
    att[0] = attach_x;
    att[1] = attach_y;
    att[2] = attach_z;
    for (int i = 0; i < 9; i++) begin
      term_nxt[i] = 54'(rot_r[i]) * 54'(att[i % 3]);
    end
  end

  // Row sums, rounded back to Q16.16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 56'(term_r[3*i]) + 56'(term_r[3*i+1]) + 56'(term_r[3*i+2]);
      off_nxt[i] = 42'((acc[i] + 56'sd8192) >>> 14);
    end
  end

  // Hip position and per-axis distance magnitude
  always_comb begin
    org[0] = beat_r[4].body_origin_x;
    org[1] = beat_r[4].body_origin_y;
    org[2] = beat_r[4].body_origin_z;
    tgt[0] = beat_r[4].target_x;
    tgt[1] = beat_r[4].target_y;
    tgt[2] = beat_r[4].target_z;
    sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      hip[i] = 44'(org[i]) + 44'(off_r[i]);
      dl[i]  = 45'(tgt[i]) - 45'(hip[i]);
      ad[i]  = dl[i][44] ? 45'(-dl[i]) : 45'(dl[i]);
      dist_nxt[i] = ad[i][31:0];
      if (ad[i][44:32] != '0) begin
        sat_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_r[0] <= in_beat;
      for (int i = 1; i < 5; i++) begin
        beat_r[i] <= beat_r[i-1];
      end
      prd_r  <= prd_nxt;
      rot_r  <= rot_nxt;
      term_r <= term_nxt;
      off_r  <= off_nxt;
      dist_r <= dist_nxt;
      sat_r  <= sat_nxt;
      out_tag.knee    <= beat_r[4].knee_angle_now;
      out_tag.clamped <= 1'b0;
      out_tag.kill    <= 1'b0;
    end
  end

  assign out_vld  = vld_r[5];
  assign out_dist = dist_r;
  assign out_sat  = sat_r;

endmodule

// File: rtl/core/tbik_reach.sv
module tbik_reach (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [2:0][31:0]    in_dist,
  input  logic                in_sat,
  input  tbik_pkg::item_tag_t in_tag,
  input  logic [30:0]         upper_length,
  input  logic [30:0]         lower_length,
  output logic                out_vld,
  output logic signed [33:0]  out_d,
  output tbik_pkg::item_tag_t out_tag
);
  import tbik_pkg::*;

  localparam int SIDE_W = 1 + $bits(item_tag_t);

  logic              sq_vld_r, sum_vld_r, fin_vld_r;
  logic [63:0]       sq_r [3];
  logic              sq_sat_r;
  item_tag_t         sq_tag_r, sum_tag_r;
  logic [65:0]       sum_full;
  logic [63:0]       sum_r;
  logic              sum_sat_r;
  logic              rt_vld;
  logic [31:0]       rt_root;
  logic [SIDE_W-1:0] rt_side;
  logic              rt_sat;
  item_tag_t         rt_tag;
  logic signed [33:0] d_raw, reach, d_nxt, d_r;
  item_tag_t         tag_nxt, tag_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r  <= 1'b0;
      sum_vld_r <= 1'b0;
      fin_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r  <= in_vld;
      sum_vld_r <= sq_vld_r;
      fin_vld_r <= rt_vld;
    end
  end

  // Square each axis, then sum with overflow detect
  assign sum_full = 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 64'(in_dist[i]) * 64'(in_dist[i]);
      end
      sq_sat_r  <= in_sat;
      sq_tag_r  <= in_tag;
      sum_r     <= sum_full[63:0];
      sum_sat_r <= sq_sat_r | (sum_full[65:64] != 2'b00);
      sum_tag_r <= sq_tag_r;
    end
  end

  tbik_isqrt #(.W(64), .SW(SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sum_vld_r),
    .in_val   (sum_r),
    .in_side  ({sum_sat_r, sum_tag_r}),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_side (rt_side)
  );

  assign rt_sat = rt_side[SIDE_W-1];
  assign rt_tag = rt_side[SIDE_W-2:0];

  // Clamp to reach, drop targets that sit on the hip
  always_comb begin
    d_raw   = rt_sat ? 34'sh0FFFFFFFF : 34'({2'b00, rt_root});
    reach   = 34'({3'b000, upper_length}) + 34'({3'b000, lower_length}) - EPS;
    tag_nxt = rt_tag;
    tag_nxt.clamped = (d_raw > reach);
    d_nxt   = tag_nxt.clamped ? reach : d_raw;
    tag_nxt.kill = !tag_nxt.clamped && (d_raw < EPS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_nxt;
      tag_r <= tag_nxt;
    end
  end

  assign out_vld = fin_vld_r;
  assign out_d   = d_r;
  assign out_tag = tag_r;

endmodule

// File: rtl/core/tbik_cos.sv
module tbik_cos (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic signed [33:0]  in_d,
  input  tbik_pkg::item_tag_t in_tag,
  input  logic [30:0]         upper_length,
  input  logic [30:0]         lower_length,
  output logic                out_vld,
  output logic [16:0]         out_cmag,
  output logic                out_neg,
  output tbik_pkg::item_tag_t out_tag
);
  import tbik_pkg::*;

  localparam int STEPS = 16;

  logic [1:0]  vld_r;
  item_tag_t   tag_r [2];

  logic [32:0] c_abs, big;
  logic [1:0]  k;
  logic [29:0] a_r, b_r, c_r;
  logic [59:0] aa_r, bb_r, cc_r, ab_r;
  logic signed [61:0] num;
  logic [60:0] den;
  logic [60:0] mag;

  logic [61:0]      rem_r  [STEPS+1];
  logic [60:0]      den_r  [STEPS+1];
  logic [STEPS-1:0] q_r    [STEPS+1];
  logic             one_r  [STEPS+1];
  logic             neg_r  [STEPS+1];
  item_tag_t        dtag_r [STEPS+1];
  logic [STEPS:0]   dvld_r;

  // Normalize so every length stays below 2^30
  always_comb begin
    c_abs = in_d[33] ? 33'(-in_d) : 33'(in_d);
    big   = {2'b00, upper_length};
    if ({2'b00, lower_length} > big) begin
      big = {2'b00, lower_length};
    end
    if (c_abs > big) begin
      big = c_abs;
    end
    if (big[32]) begin
      k = 2'd3;
    end else if (big[31]) begin
      k = 2'd2;
    end else if (big[30]) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
  end

  // Law of cosines numerator and denominator
  always_comb begin
    num = 62'(aa_r) + 62'(bb_r) - 62'(cc_r);
    den = {ab_r, 1'b0};
    mag = num[61] ? 61'(-num) : 61'(num);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      dvld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[0], in_vld};
      dvld_r[0] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= 30'({2'b00, upper_length} >> k);
      b_r <= 30'({2'b00, lower_length} >> k);
      c_r <= 30'(c_abs >> k);
      tag_r[0] <= in_tag;
      aa_r <= 60'(a_r) * 60'(a_r);
      bb_r <= 60'(b_r) * 60'(b_r);
      cc_r <= 60'(c_r) * 60'(c_r);
      ab_r <= 60'(a_r) * 60'(b_r);
      tag_r[1] <= tag_r[0];
      rem_r[0]  <= {1'b0, mag};
      den_r[0]  <= den;
      q_r[0]    <= '0;
      one_r[0]  <= (den == '0) || (mag >= den);
      neg_r[0]  <= num[61];
      dtag_r[0] <= tag_r[1];
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 0; j < STEPS; j++) begin : g_div
    logic [62:0] shl;

    assign shl = {rem_r[j], 1'b0};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[j+1] <= 1'b0;
      end else if (en) begin
        dvld_r[j+1] <= dvld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (shl >= {2'b00, den_r[j]}) begin
          rem_r[j+1] <= 62'(shl - {2'b00, den_r[j]});
          q_r[j+1]   <= {q_r[j][STEPS-2:0], 1'b1};
        end else begin
          rem_r[j+1] <= shl[61:0];
          q_r[j+1]   <= {q_r[j][STEPS-2:0], 1'b0};
        end
        den_r[j+1]  <= den_r[j];
        one_r[j+1]  <= one_r[j];
        neg_r[j+1]  <= neg_r[j];
        dtag_r[j+1] <= dtag_r[j];
      end
    end
  end

  assign out_vld  = dvld_r[STEPS];
  assign out_cmag = one_r[STEPS] ? COS_ONE : {1'b0, q_r[STEPS]};
  assign out_neg  = neg_r[STEPS];
  assign out_tag  = dtag_r[STEPS];

endmodule

// File: rtl/core/tbik_acos.sv
module tbik_acos (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [16:0]         in_cmag,
  input  logic                in_neg,
  input  tbik_pkg::item_tag_t in_tag,
  output logic                out_vld,
  output logic signed [31:0]  out_vel,
  output tbik_pkg::item_tag_t out_tag
);
  import tbik_pkg::*;

  localparam int SIDE_W = 17 + 1 + $bits(item_tag_t);

  logic              rt_vld;
  logic [16:0]       rt_root;
  logic [SIDE_W-1:0] rt_side;
  logic [33:0]       sq_in;

  logic [5:0]         vld_r;
  logic [16:0]        x_r   [2];
  logic [16:0]        s_r   [3];
  logic               neg_r [4];
  item_tag_t          tag_r [6];
  logic signed [35:0] p1_r, p2_r, p3_r;
  logic signed [43:0] t1;
  logic signed [53:0] t2, t3;
  logic signed [53:0] prod_r;
  logic signed [37:0] ang, angf_r;
  logic signed [37:0] bend_full;
  logic signed [21:0] bend;
  logic signed [22:0] err;
  logic signed [39:0] v40;
  logic signed [31:0] vel_r, vel_nxt;

  // sqrt(1 - |c|) in Q16 from a Q32 radicand
  assign sq_in = 34'({COS_ONE - in_cmag, 16'h0000});

  tbik_isqrt #(.W(34), .SW(SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_vld),
    .in_val   (sq_in),
    .in_side  ({in_cmag, in_neg, in_tag}),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_side (rt_side)
  );

  // Horner steps of the cubic, floor shifts
  always_comb begin
    t1 = 44'(AC3) * 44'($signed({1'b0, rt_side[SIDE_W-1 -: 17]}));
    t2 = 54'(p1_r) * 54'($signed({1'b0, x_r[0]}));
    t3 = 54'(p2_r) * 54'($signed({1'b0, x_r[1]}));
  end

  // Fold in the sign, then bend error and velocity
  always_comb begin
    ang       = 38'((prod_r + 54'sd32768) >>> 16);
    bend_full = (PI_Q30 - angf_r + (38'sd1 <<< (29 - ANGLE_FRAC_BITS)))
                >>> (30 - ANGLE_FRAC_BITS);
    bend      = 22'(bend_full);
    err       = 23'(bend) - 23'(tag_r[4].knee);
    v40       = 40'(err) * 40'sd10 * 40'(1 << (POS_FRAC_BITS - ANGLE_FRAC_BITS));
    if (v40 > 40'sh007FFFFFFF) begin
      vel_nxt = 32'sh7FFFFFFF;
    end else if (v40 < -40'sh0080000000) begin
      vel_nxt = 32'sh80000000;
    end else begin
      vel_nxt = 32'(v40);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], rt_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r     <= 36'(t1 >>> 16) + AC2;
      x_r[0]   <= rt_side[SIDE_W-1 -: 17];
      s_r[0]   <= rt_root;
      neg_r[0] <= rt_side[$bits(item_tag_t)];
      tag_r[0] <= rt_side[$bits(item_tag_t)-1:0];

      p2_r     <= 36'(t2 >>> 16) + AC1;
      x_r[1]   <= x_r[0];
      p3_r     <= 36'(t3 >>> 16) + AC0;
      prod_r   <= 54'(p3_r) * 54'($signed({1'b0, s_r[2]}));
      angf_r   <= neg_r[3] ? (PI_Q30 - ang) : ang;
      vel_r    <= vel_nxt;
      for (int i = 1; i < 3; i++) begin
        s_r[i] <= s_r[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        neg_r[i] <= neg_r[i-1];
      end
      for (int i = 1; i < 6; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  assign out_vld = vld_r[5];
  assign out_vel = vel_r;
  assign out_tag = tag_r[5];

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import tbik_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  two_bone_ik_knee_drive i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the limb registers
  logic        lim_enable;
  logic [3:0]  lim_segs;
  logic [30:0] lim_upper;
  logic [30:0] lim_lower;
  logic signed [31:0] lim_attach [3];

  out_beat_t knee_cmd_q [$];
  int        fail_count;
  int        send_idle_pct;
  int        recv_stall_pct;

  localparam longint PI_FIX = 64'sd3373259426;
  localparam longint C0 = 64'sd1686557207;
  localparam longint C1 = -64'sd227756103;
  localparam longint C2 = 64'sd79737142;
  localparam longint C3 = -64'sd20110433;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #300ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Floor shift for signed values
  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint round_shr(longint x, int s);
    if (s == 0) return x;
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint acos_q30(longint x);
    longint p;
    longint s;
    p = floor_shr(C3 * x, 16) + C2;
    p = floor_shr(p * x, 16) + C1;
    p = floor_shr(p * x, 16) + C0;
    s = longint'(int_sqrt(64'(65536 - x) << 16));
    return round_shr(p * s, 16);
  endfunction

  // Solve one limb: hip placement, reach clamp, cosine law, knee velocity
  function automatic out_beat_t solve_knee(in_beat_t b);
    out_beat_t   res;
    longint      o [3];
    longint      t [3];
    longint      mr [3][3];
    longint      w, x, y, z, q1, hip, dl, d, reach, num, ang, bend, v;
    logic [63:0] sum, ad, sq, a, bb, c, den, mag, big, q, rem;
    logic        sat, neg;
    int          k;
    res = '0;
    if (lim_enable != 1'b1 || lim_segs != SEG_COUNT_TWO) return res;
    o[0] = b.body_origin_x; o[1] = b.body_origin_y; o[2] = b.body_origin_z;
    t[0] = b.target_x; t[1] = b.target_y; t[2] = b.target_z;
    w = b.rot_w; x = b.rot_x; y = b.rot_y; z = b.rot_z;
    q1 = 64'sd1 <<< 28;
    mr[0][0] = q1 - 2 * (y * y + z * z);
    mr[0][1] = 2 * (x * y - w * z);
    mr[0][2] = 2 * (x * z + w * y);
    mr[1][0] = 2 * (x * y + w * z);
    mr[1][1] = q1 - 2 * (x * x + z * z);
    mr[1][2] = 2 * (y * z - w * x);
    mr[2][0] = 2 * (x * z - w * y);
    mr[2][1] = 2 * (y * z + w * x);
    mr[2][2] = q1 - 2 * (x * x + y * y);
    sum = 0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      hip = 0;
      for (int j = 0; j < 3; j++) hip += round_shr(mr[i][j], 14) * longint'(lim_attach[j]);
      hip = o[i] + round_shr(hip, 14);
      dl = t[i] - hip;
      ad = dl < 0 ? -dl : dl;
      if (ad >= (64'd1 << 32)) begin
        sat = 1'b1;
      end else begin
        sq = ad * ad;
        if (sum > ~64'd0 - sq) sat = 1'b1;
        else sum += sq;
      end
    end
    d = sat ? 64'sd4294967295 : longint'(int_sqrt(sum));
    reach = longint'(lim_upper) + longint'(lim_lower) - longint'(EPS_INT);
    if (d > reach) begin
      d = reach;
      res.reach_clamped = 1'b1;
    end else if (d < EPS_INT) begin
      return '0;
    end
    a = lim_upper;
    bb = lim_lower;
    c = d < 0 ? -d : d;
    big = a > bb ? a : bb;
    if (c > big) big = c;
    k = 0;
    while ((big >> k) >= (64'd1 << 30)) k++;
    a >>= k; bb >>= k; c >>= k;
    num = longint'(a * a + bb * bb) - longint'(c * c);
    den = 2 * a * bb;
    neg = num < 0;
    mag = neg ? -num : num;
    if (den == 0 || mag >= den) begin
      q = 65536;
    end else begin
      q = 0;
      rem = mag;
      for (int i = 0; i < 16; i++) begin
        rem <<= 1;
        q <<= 1;
        if (rem >= den) begin
          rem -= den;
          q |= 1;
        end
      end
    end
    ang = acos_q30(longint'(q));
    if (neg) ang = PI_FIX - ang;
    bend = round_shr(PI_FIX - ang, 30 - ANGLE_FRAC_BITS);
    v = 10 * (bend - longint'(b.knee_angle_now));
    if (POS_FRAC_BITS >= ANGLE_FRAC_BITS) v = v * (64'sd1 <<< (POS_FRAC_BITS - ANGLE_FRAC_BITS));
    else v = round_shr(v, ANGLE_FRAC_BITS - POS_FRAC_BITS);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    res.motor_velocity = v[31:0];
    res.command_valid = 1'b1;
    return res;
  endfunction

  // Drive the result stall and check each beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (knee_cmd_q.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, out_data);
          fail_count++;
        end else begin
          out_beat_t exp_cmd;
          exp_cmd = knee_cmd_q.pop_front();
          if (exp_cmd.motor_velocity !== out_data.motor_velocity ||
              exp_cmd.command_valid !== out_data.command_valid ||
              exp_cmd.reach_clamped !== out_data.reach_clamped) begin
            $display("%0t: mismatch expected vel=%0d cv=%b rc=%b actual vel=%0d cv=%b rc=%b",
                     $time, exp_cmd.motor_velocity, exp_cmd.command_valid,
                     exp_cmd.reach_clamped, out_data.motor_velocity,
                     out_data.command_valid, out_data.reach_clamped);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Send one beat, with random idle cycles before it; valid stays up until the next call
  task automatic send_limb(in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    knee_cmd_q = {knee_cmd_q, solve_knee(b)};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted beat has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (knee_cmd_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ENABLE:    lim_enable    = val[0];
      REG_SEG_COUNT: lim_segs      = val[3:0];
      REG_UPPER_LEN: lim_upper     = val[30:0];
      REG_LOWER_LEN: lim_lower     = val[30:0];
      REG_ATTACH_X:  lim_attach[0] = val;
      REG_ATTACH_Y:  lim_attach[1] = val;
      default:       lim_attach[2] = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(8 << 16))) - (4 << 16);
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'($signed($urandom_range(1 << 18))) - (1 << 17);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_quat();
    return 16'($signed($urandom_range(32768))) - 16'sd16384;
  endfunction

  // Random pose, target mostly near the body origin, unit-ish quaternion or arbitrary one
  function automatic in_beat_t rand_limb();
    in_beat_t b;
    b.body_origin_x = rand_pos();
    b.body_origin_y = rand_pos();
    b.body_origin_z = rand_pos();
    if ($urandom_range(1)) begin
      b.rot_w = 16'sd16384; b.rot_x = '0; b.rot_y = '0; b.rot_z = '0;
      case ($urandom_range(2))
        0: b.rot_x = rand_quat();
        1: b.rot_y = rand_quat();
        default: b.rot_z = rand_quat();
      endcase
      b.rot_w = 16'(16'sd16384 - (b.rot_x < 0 ? -b.rot_x : b.rot_x) / 4
                - (b.rot_y < 0 ? -b.rot_y : b.rot_y) / 4
                - (b.rot_z < 0 ? -b.rot_z : b.rot_z) / 4);
    end else begin
      b.rot_w = rand_quat(); b.rot_x = rand_quat();
      b.rot_y = rand_quat(); b.rot_z = rand_quat();
    end
    if ($urandom_range(3) != 0) begin
      b.target_x = b.body_origin_x + 32'($signed($urandom_range(6 << 16))) - (3 << 16);
      b.target_y = b.body_origin_y + 32'($signed($urandom_range(6 << 16))) - (3 << 16);
      b.target_z = b.body_origin_z + 32'($signed($urandom_range(6 << 16))) - (3 << 16);
    end else begin
      b.target_x = rand_pos(); b.target_y = rand_pos(); b.target_z = rand_pos();
    end
    b.knee_angle_now = 16'($signed($urandom_range(51472))) - 16'sd25736;
    return b;
  endfunction

  task automatic set_idle(int s, int r);
    send_idle_pct  = s;
    recv_stall_pct = r;
  endtask

  // Field extremes, gating registers, near target, zero, tiny and maximum lengths
  task automatic test_directed();
    in_beat_t b;
    b = '0;
    b.rot_w = 16'sd16384;
    b.target_x = 32'sd65536;
    send_limb(b);
    wait_drain();
    write_reg(REG_ENABLE, 32'd1);
    send_limb(b);
    b.knee_angle_now = 16'sd25736;  send_limb(b);
    b.knee_angle_now = -16'sd25736; send_limb(b);
    b.target_x = 32'sd100;          send_limb(b);
    b.target_x = 32'sd0;            send_limb(b);
    b.target_x = 32'sh7fffffff;
    b.body_origin_x = 32'sh80000000;
    send_limb(b);
    b.body_origin_y = 32'sh7fffffff;
    b.target_y = 32'sh80000000;
    b.body_origin_z = 32'sh80000000;
    b.target_z = 32'sh7fffffff;
    send_limb(b);
    b = '0;
    b.rot_w = -16'sd16384; b.rot_x = 16'sd16384; b.rot_y = -16'sd16384; b.rot_z = 16'sd16384;
    b.target_y = 32'sd90000;
    send_limb(b);
    b.rot_w = 16'hffff; b.rot_x = 16'hffff; b.rot_y = 16'hffff; b.rot_z = 16'hffff;
    send_limb(b);
    wait_drain();
    for (int s = 0; s <= 8; s += 4) begin
      write_reg(REG_SEG_COUNT, 32'(s));
      send_limb(b);
      wait_drain();
    end
    write_reg(REG_SEG_COUNT, 32'(SEG_COUNT_TWO));
    write_reg(REG_UPPER_LEN, 32'd0);
    write_reg(REG_LOWER_LEN, 32'd1);
    send_limb(b);
    wait_drain();
    write_reg(REG_UPPER_LEN, 32'h7fffffff);
    write_reg(REG_LOWER_LEN, 32'h7fffffff);
    b.target_x = 32'sh40000000;
    send_limb(b);
    b.target_x = 32'sh7fffffff; b.body_origin_x = 32'sh80000000;
    send_limb(b);
    wait_drain();
  endtask

  // Random limbs under one register setting and one idle pattern
  task automatic test_random_phase(int n, int s, int r);
    set_idle(s, r);
    repeat (n) send_limb(rand_limb());
    wait_drain();
  endtask

  task automatic test_attach_and_lengths();
    write_reg(REG_UPPER_LEN, 32'd65536);
    write_reg(REG_LOWER_LEN, 32'd98304);
    write_reg(REG_ATTACH_X, 32'h00010000);
    write_reg(REG_ATTACH_Y, 32'hffff8000);
    write_reg(REG_ATTACH_Z, 32'h00004000);
    test_random_phase(150, 0, 0);
    write_reg(REG_ATTACH_X, 32'h7fffffff);
    write_reg(REG_ATTACH_Y, 32'h80000000);
    write_reg(REG_ATTACH_Z, $urandom);
    test_random_phase(60, 78, 0);
    write_reg(REG_ATTACH_X, 32'd0);
    write_reg(REG_ATTACH_Y, 32'd0);
    write_reg(REG_ATTACH_Z, 32'd0);
    write_reg(REG_UPPER_LEN, 32'd1);
    write_reg(REG_LOWER_LEN, 32'd1);
    test_random_phase(40, 0, 78);
    write_reg(REG_UPPER_LEN, $urandom_range(4 << 16));
    write_reg(REG_LOWER_LEN, $urandom_range(4 << 16));
    write_reg(REG_ATTACH_X, $urandom_range(1 << 17));
    test_random_phase(150, 78, 0);
  endtask

  task automatic test_default_geometry();
    write_reg(REG_UPPER_LEN, 32'd65536);
    write_reg(REG_LOWER_LEN, 32'd65536);
    write_reg(REG_ATTACH_X, 32'd0);
    test_random_phase(120, 0, 78);
    test_random_phase(120, 21, 21);
    write_reg(REG_ENABLE, 32'd0);
    test_random_phase(20, 21, 21);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    out_stall  = 1'b0;
    fail_count = 0;
    lim_enable = 1'b0;
    lim_segs   = SEG_COUNT_TWO;
    lim_upper  = 31'd65536;
    lim_lower  = 31'd65536;
    lim_attach = '{0, 0, 0};
    set_idle(0, 0);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_attach_and_lengths();
    test_default_geometry();
    if (fail_count == 0 && knee_cmd_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: two_bone_ik_knee_drive.f
rtl/core/tbik_pkg.sv
rtl/core/tbik_isqrt.sv
rtl/core/tbik_hip.sv
rtl/core/tbik_reach.sv
rtl/core/tbik_cos.sv
rtl/core/tbik_acos.sv
rtl/core/two_bone_ik_knee_drive.sv
sim/tb.sv
